/* design/skin4_pkg.sv */
// Types and constants shared by the skinning influence table block.
// No dependencies.
package skin4_pkg;

	localparam int SLOTS   = 4;
	localparam int SLOT_W  = 2;
	localparam int WGT_W   = 16;
	localparam int JNT_W   = 8;
	localparam int CNT_W   = 3;
	localparam int VTX_W   = 12;
	localparam int SUM_W   = 18;
	localparam int NUM_W   = 32;
	localparam int QB_W    = 4;
	localparam logic [WGT_W-1:0] ONE_Q16 = 16'hFFFF;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FETCH,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		action_t            action;
		logic [VTX_W-1:0]   vertex;
		logic [JNT_W-1:0]   joint;
		logic [WGT_W-1:0]   weight;
	} req_t;

	typedef struct packed {
		logic [JNT_W-1:0]   joint_a;
		logic [JNT_W-1:0]   joint_b;
		logic [JNT_W-1:0]   joint_c;
		logic [JNT_W-1:0]   joint_d;
		logic [WGT_W-1:0]   norm_weight_a;
		logic [WGT_W-1:0]   norm_weight_b;
		logic [WGT_W-1:0]   norm_weight_c;
		logic [WGT_W-1:0]   norm_weight_d;
		logic               empty_default;
	} rsp_t;

	typedef struct packed {
		logic [CNT_W-1:0]              count;
		logic [SLOTS-1:0][WGT_W-1:0]   weight;
		logic [SLOTS-1:0][JNT_W-1:0]   joint;
	} entry_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

/* design/skin4_table.sv */
// Per-vertex influence table: one write port, one registered read port.
// Depends on skin4_pkg.
module skin4_table #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  skin4_pkg::entry_t wr_data,
	input  logic              rd_en,
	input  logic [AW-1:0]     rd_addr,
	output skin4_pkg::entry_t rd_data
);
	import skin4_pkg::*;

	entry_t mem [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

/* design/skin4_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle, 16-bit quotient.
// Depends on skin4_pkg; requires numer[31:16] < denom.
module skin4_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [skin4_pkg::NUM_W-1:0]  numer,
	input  logic [skin4_pkg::SUM_W-1:0]  denom,
	output skin4_pkg::div_stat_t         stat,
	output logic [skin4_pkg::WGT_W-1:0]  quot
);
	import skin4_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [QB_W-1:0]   cnt_q;
	logic [SUM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  den_q;
	logic [WGT_W-1:0]  lo_q;
	logic [WGT_W-1:0]  quot_q;
	logic [SUM_W:0]    trial;
	logic [SUM_W:0]    diff;
	logic              ge;

	assign trial = {rem_q, lo_q[WGT_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == QB_W'(WGT_W - 1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + QB_W'(1);
				if (cnt_q == QB_W'(WGT_W - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= SUM_W'(numer[NUM_W-1:WGT_W]);
			lo_q  <= numer[WGT_W-1:0];
			den_q <= denom;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			lo_q   <= {lo_q[WGT_W-2:0], 1'b0};
			quot_q <= {quot_q[WGT_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quot      = quot_q;

endmodule

/* design/skin_influence_top4_accumulator_top.sv */
// Top level of the top-four skinning influence table with normalized read-back.
// Depends on skin4_pkg, skin4_table, skin4_div.
//
//  channel | signals                     | beat
//  --------+-----------------------------+-------------------------------------
//  req     | req_valid, req_ready, req   | action, vertex, joint, weight
//  rsp     | rsp_valid, rsp_ready, rsp   | four joints, four Q0.16 weights, empty flag
//
// Add: table read, then write back (ignored if vertex or joint is out of range).
// Clear: one entry zeroed per cycle over the whole table (4096 entries by default).
// Read: table read, four passes of the bit-serial divider, result load; with a
// zero sum, table read then result load; for a vertex out of range, result load.
// After reset the same clearing sweep runs before req_ready first rises.
// A result waits in the rsp register while requests are taken; a second stalls them.
module skin_influence_top4_accumulator_top #(
	parameter int NUM_VERTICES = 4096,
	parameter int NUM_BONES    = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  skin4_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output skin4_pkg::rsp_t rsp
);
	import skin4_pkg::*;

	localparam int DEPTH = (NUM_VERTICES < (1 << VTX_W)) ? NUM_VERTICES : (1 << VTX_W);
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	state_t                    state_q, state_d;
	req_t                      req_q;
	entry_t                    ent_q;
	logic [SUM_W-1:0]          sum_q;
	logic [SLOT_W-1:0]         slot_q;
	logic [SLOTS-1:0][WGT_W-1:0] nw_q;
	logic                      empty_q;
	logic [AW-1:0]             clr_addr_q;
	rsp_t                      rsp_q, rsp_d;
	logic                      rsp_valid_q;

	logic                      accept;
	logic                      vtx_ok;
	logic                      jnt_ok;
	logic                      clr_last;
	logic                      load_rsp;

	logic                      tbl_wr_en;
	logic [AW-1:0]             tbl_wr_addr;
	entry_t                    tbl_wr_data;
	entry_t                    rd_data;
	entry_t                    upd;
	logic                      upd_wr;
	logic [SUM_W-1:0]          sum_d;

	logic                      div_start;
	logic [NUM_W-1:0]          div_numer;
	div_stat_t                 div_stat;
	logic [WGT_W-1:0]          div_quot;
	logic [WGT_W-1:0]          slot_w;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign vtx_ok    = 32'(req.vertex) < NUM_VERTICES;
	assign jnt_ok    = 32'(req.joint) < NUM_BONES;
	assign clr_last  = (clr_addr_q == AW'(DEPTH - 1));
	assign load_rsp  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready);

	skin4_table #(
		.DEPTH(DEPTH),
		.AW   (AW)
	) u_table (
		.clk    (clk),
		.wr_en  (tbl_wr_en),
		.wr_addr(tbl_wr_addr),
		.wr_data(tbl_wr_data),
		.rd_en  (accept),
		.rd_addr(req.vertex[AW-1:0]),
		.rd_data(rd_data)
	);

	assign slot_w    = ent_q.weight[slot_q];
	assign div_numer = {slot_w, {WGT_W{1'b0}}} - {{WGT_W{1'b0}}, slot_w};
	assign div_start = (state_q == ST_DIV_GO);

	skin4_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.numer (div_numer),
		.denom (sum_q),
		.stat  (div_stat),
		.quot  (div_quot)
	);

	assign sum_d = SUM_W'(rd_data.weight[0]) + SUM_W'(rd_data.weight[1])
		+ SUM_W'(rd_data.weight[2]) + SUM_W'(rd_data.weight[3]);

	always_comb begin
		logic [SLOT_W-1:0] low;
		upd    = rd_data;
		upd_wr = 1'b0;
		low    = '0;
		if (rd_data.count < CNT_W'(SLOTS)) begin
			upd.weight[rd_data.count[SLOT_W-1:0]] = req_q.weight;
			upd.joint[rd_data.count[SLOT_W-1:0]]  = req_q.joint;
			upd.count                             = rd_data.count + CNT_W'(1);
			upd_wr                                = 1'b1;
		end else begin
			for (int k = 1; k < SLOTS; k++) begin
				if (rd_data.weight[k] < rd_data.weight[low]) begin
					low = SLOT_W'(k);
				end
			end
			if (rd_data.weight[low] < req_q.weight) begin
				upd.weight[low] = req_q.weight;
				upd.joint[low]  = req_q.joint;
				upd_wr          = 1'b1;
			end
		end
	end

	always_comb begin
		state_d     = state_q;
		tbl_wr_en   = 1'b0;
		tbl_wr_addr = req_q.vertex[AW-1:0];
		tbl_wr_data = upd;
		case (state_q)
			ST_CLEAR: begin
				tbl_wr_en   = 1'b1;
				tbl_wr_addr = clr_addr_q;
				tbl_wr_data = '0;
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					case (req.action)
						ACT_CLEAR: state_d = ST_CLEAR;
						ACT_ADD:   state_d = (vtx_ok && jnt_ok) ? ST_FETCH : ST_IDLE;
						ACT_READ:  state_d = vtx_ok ? ST_FETCH : ST_FINISH;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_FETCH: begin
				if (req_q.action == ACT_ADD) begin
					tbl_wr_en = upd_wr;
					state_d   = ST_IDLE;
				end else begin
					state_d = (sum_d == '0) ? ST_FINISH : ST_DIV_GO;
				end
			end
			ST_DIV_GO: begin
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (div_stat.done) begin
					state_d = (slot_q == SLOT_W'(SLOTS - 1)) ? ST_FINISH : ST_DIV_GO;
				end
			end
			ST_FINISH: begin
				if (load_rsp) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		rsp_d = '0;
		if (empty_q) begin
			rsp_d.norm_weight_a = ONE_Q16;
			rsp_d.empty_default = 1'b1;
		end else begin
			rsp_d.joint_a       = ent_q.joint[0];
			rsp_d.joint_b       = ent_q.joint[1];
			rsp_d.joint_c       = ent_q.joint[2];
			rsp_d.joint_d       = ent_q.joint[3];
			rsp_d.norm_weight_a = nw_q[0];
			rsp_d.norm_weight_b = nw_q[1];
			rsp_d.norm_weight_c = nw_q[2];
			rsp_d.norm_weight_d = nw_q[3];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_addr_q  <= '0;
			slot_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_addr_q <= clr_last ? '0 : clr_addr_q + AW'(1);
			end
			if (state_q == ST_FETCH) begin
				slot_q <= '0;
			end else if (state_q == ST_DIV_WAIT && div_stat.done) begin
				slot_q <= slot_q + SLOT_W'(1);
			end
			if (load_rsp) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q   <= req;
			empty_q <= 1'b1;
		end
		if (state_q == ST_FETCH) begin
			ent_q   <= rd_data;
			sum_q   <= sum_d;
			empty_q <= (sum_d == '0);
		end
		if (state_q == ST_DIV_WAIT && div_stat.done) begin
			nw_q[slot_q] <= div_quot;
		end
		if (load_rsp) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish state");

	a_default_shape: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.empty_default |-> rsp.norm_weight_a == ONE_Q16
			&& rsp.norm_weight_b == '0 && rsp.joint_a == '0)
		else $error("default result malformed");

	a_norm_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.empty_default |-> (SUM_W'(rsp.norm_weight_a)
			+ SUM_W'(rsp.norm_weight_b) + SUM_W'(rsp.norm_weight_c)
			+ SUM_W'(rsp.norm_weight_d)) <= SUM_W'(ONE_Q16))
		else $error("normalized weights exceed one");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		tbl_wr_en |-> tbl_wr_data.count <= CNT_W'(SLOTS))
		else $error("slot count beyond four");

	a_div_done_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> state_q == ST_DIV_WAIT && !div_stat.busy)
		else $error("divider finished out of sequence");
`endif

endmodule

/* bench/skin4_influence_checker.sv */
// Checker for the top-four skinning influence table: watches both channels,
// keeps its own copy of the table, predicts each read beat and compares it.
// Depends on skin4_pkg.
module skin4_influence_checker #(
	parameter int NUM_VERTICES = 4096,
	parameter int NUM_BONES    = 256
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	input  logic            req_ready,
	input  skin4_pkg::req_t req,
	input  logic            rsp_valid,
	input  logic            rsp_ready,
	input  skin4_pkg::rsp_t rsp,
	output int              errors,
	output int              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import skin4_pkg::*;

	entry_t influence_tbl [NUM_VERTICES];
	rsp_t   normalized_q [$];

	initial begin
		errors = 0;
		pending = 0;
	end

	function automatic void wipe_table();
		for (int v = 0; v < NUM_VERTICES; v++)
			influence_tbl[v] = '0;
	endfunction

	function automatic void expect_beat(input rsp_t b);
		normalized_q = {normalized_q, b};
	endfunction

	function automatic void merge_influence(input logic [VTX_W-1:0] v,
			input logic [JNT_W-1:0] j, input logic [WGT_W-1:0] w);
		entry_t e;
		int     low;
		if (v >= NUM_VERTICES || j >= NUM_BONES)
			return;
		e = influence_tbl[v];
		if (e.count < SLOTS) begin
			e.weight[e.count] = w;
			e.joint[e.count] = j;
			e.count = e.count + 1'b1;
		end else begin
			low = 0;
			for (int k = 1; k < SLOTS; k++)
				if (e.weight[k] < e.weight[low])
					low = k;
			if (e.weight[low] < w) begin
				e.weight[low] = w;
				e.joint[low] = j;
			end
		end
		influence_tbl[v] = e;
	endfunction

	function automatic logic [WGT_W-1:0] q16_share(input logic [WGT_W-1:0] w,
			input logic [SUM_W-1:0] sum);
		return WGT_W'((64'(w) * 64'(ONE_Q16)) / 64'(sum));
	endfunction

	function automatic rsp_t normalized_read(input logic [VTX_W-1:0] v);
		rsp_t             o;
		entry_t           e;
		logic [SUM_W-1:0] sum;
		o = '0;
		e = '0;
		sum = '0;
		if (v < NUM_VERTICES) begin
			e = influence_tbl[v];
			for (int k = 0; k < SLOTS; k++)
				sum += SUM_W'(e.weight[k]);
		end
		if (sum == 0) begin
			o.norm_weight_a = ONE_Q16;
			o.empty_default = 1'b1;
			return o;
		end
		o.joint_a = e.joint[0];
		o.joint_b = e.joint[1];
		o.joint_c = e.joint[2];
		o.joint_d = e.joint[3];
		o.norm_weight_a = q16_share(e.weight[0], sum);
		o.norm_weight_b = q16_share(e.weight[1], sum);
		o.norm_weight_c = q16_share(e.weight[2], sum);
		o.norm_weight_d = q16_share(e.weight[3], sum);
		return o;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	task automatic compare_beat(input rsp_t got);
		rsp_t want;
		if (normalized_q.size() == 0) begin
			$error("rsp beat arrived with nothing expected");
			errors++;
			return;
		end
		want = normalized_q.pop_front();
		check_field("joint_a", want.joint_a, got.joint_a);
		check_field("joint_b", want.joint_b, got.joint_b);
		check_field("joint_c", want.joint_c, got.joint_c);
		check_field("joint_d", want.joint_d, got.joint_d);
		check_field("norm_weight_a", want.norm_weight_a, got.norm_weight_a);
		check_field("norm_weight_b", want.norm_weight_b, got.norm_weight_b);
		check_field("norm_weight_c", want.norm_weight_c, got.norm_weight_c);
		check_field("norm_weight_d", want.norm_weight_d, got.norm_weight_d);
		check_field("empty_default", want.empty_default, got.empty_default);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wipe_table();
			normalized_q.delete();
			pending <= 0;
		end else begin
			if (req_valid && req_ready) begin
				case (req.action)
					ACT_CLEAR: wipe_table();
					ACT_ADD:   merge_influence(req.vertex, req.joint, req.weight);
					ACT_READ:  expect_beat(normalized_read(req.vertex));
					default: ;
				endcase
			end
			if (rsp_valid && rsp_ready)
				compare_beat(rsp);
			pending <= normalized_q.size();
		end
	end

endmodule

/* bench/tb_skin_influence_top4_accumulator_top.sv */
// Testbench top for the top-four skinning influence table: drives directed and
// random request beats under varying back-pressure and gives the verdict.
// Depends on skin4_pkg, skin_influence_top4_accumulator_top, skin4_influence_checker.
module tb_skin_influence_top4_accumulator_top;
	timeunit 1ns;
	timeprecision 1ps;

	import skin4_pkg::*;

	localparam int VERTS           = 4096;
	localparam int BONES           = 256;
	localparam int INFLUENCE_ITEMS = 500;
	localparam int HOLD_CYCLES     = 400;
	localparam int DRAIN_CYCLES    = 4200;
	localparam int CYCLE_LIMIT     = 1_000_000;

	typedef enum logic [1:0] {
		PACE_LAZY_SINK,
		PACE_LAZY_SOURCE,
		PACE_FULL
	} pace_t;

	logic  clk       = 1'b0;
	logic  arst_n    = 1'b0;
	logic  req_valid = 1'b0;
	logic  req_ready;
	req_t  req       = '0;
	logic  rsp_valid;
	logic  rsp_ready = 1'b0;
	rsp_t  rsp;
	pace_t pace      = PACE_LAZY_SINK;
	int    errors;
	int    pending;
	int    cycles    = 0;
	int    hold_left = 0;
	bit    held      = 1'b0;
	req_t  plan [$];

	skin_influence_top4_accumulator_top #(
		.NUM_VERTICES(VERTS),
		.NUM_BONES   (BONES)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

	skin4_influence_checker #(
		.NUM_VERTICES(VERTS),
		.NUM_BONES   (BONES)
	) i_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.errors   (errors),
		.pending  (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// hold off once at the start of the free-running pace so the block backs up
	always @(posedge clk) begin
		if (pace == PACE_FULL && !held) begin
			held <= 1'b1;
			hold_left <= HOLD_CYCLES;
			rsp_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_ready <= 1'b0;
		end else begin
			case (pace)
				PACE_LAZY_SINK:   rsp_ready <= $urandom_range(99) >= 70;
				PACE_LAZY_SOURCE: rsp_ready <= $urandom_range(99) >= 36;
				default:          rsp_ready <= 1'b1;
			endcase
		end
	end

	function automatic req_t mk_req(input action_t a, input int v, input int j, input int w);
		req_t r;
		r.action = a;
		r.vertex = VTX_W'(v);
		r.joint = JNT_W'(j);
		r.weight = WGT_W'(w);
		return r;
	endfunction

	function automatic void plan_beat(input req_t r);
		plan = {plan, r};
	endfunction

	function automatic req_t random_req(input bit read_only);
		req_t r;
		int   pick;
		pick = $urandom_range(99);
		if (read_only || pick < 35)
			r.action = ACT_READ;
		else if (pick < 36)
			r.action = ACT_CLEAR;
		else if (pick < 39)
			r.action = ACT_NONE;
		else
			r.action = ACT_ADD;
		r.vertex = ($urandom_range(4) == 0) ? VTX_W'($urandom) : VTX_W'($urandom_range(15));
		r.joint = JNT_W'($urandom);
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: r.weight = '0;
					1: r.weight = WGT_W'(1);
					2: r.weight = ONE_Q16;
					default: r.weight = WGT_W'(16'h8000);
				endcase
			end
			1: r.weight = WGT_W'($urandom_range(15));
			default: r.weight = WGT_W'($urandom);
		endcase
		return r;
	endfunction

	task automatic send_beat(input req_t r, input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req <= r;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
	endtask

	initial begin
		req_t  r;
		int    counted;
		pace_t cur;
		// empty entry, then extremes of joint and weight
		plan_beat(mk_req(ACT_READ, 0, 0, 0));
		plan_beat(mk_req(ACT_ADD, 0, 255, 65535));
		plan_beat(mk_req(ACT_ADD, 0, 0, 0));
		plan_beat(mk_req(ACT_READ, 0, 0, 0));
		plan_beat(mk_req(ACT_ADD, 4095, 170, 21845));
		plan_beat(mk_req(ACT_ADD, 4095, 85, 43690));
		plan_beat(mk_req(ACT_READ, 4095, 0, 0));
		// fill, then a tie that must not replace and a win on the first smallest slot
		plan_beat(mk_req(ACT_ADD, 1, 1, 100));
		plan_beat(mk_req(ACT_ADD, 1, 2, 50));
		plan_beat(mk_req(ACT_ADD, 1, 3, 50));
		plan_beat(mk_req(ACT_ADD, 1, 4, 200));
		plan_beat(mk_req(ACT_ADD, 1, 9, 50));
		plan_beat(mk_req(ACT_ADD, 1, 10, 51));
		plan_beat(mk_req(ACT_READ, 1, 0, 0));
		// full entry with zero sum reads as default
		plan_beat(mk_req(ACT_ADD, 2, 7, 0));
		plan_beat(mk_req(ACT_ADD, 2, 8, 0));
		plan_beat(mk_req(ACT_ADD, 2, 9, 0));
		plan_beat(mk_req(ACT_ADD, 2, 10, 0));
		plan_beat(mk_req(ACT_READ, 2, 0, 0));
		plan_beat(mk_req(ACT_ADD, 2, 11, 1));
		plan_beat(mk_req(ACT_READ, 2, 0, 0));
		plan_beat(mk_req(ACT_NONE, 4095, 255, 65535));
		plan_beat(mk_req(ACT_CLEAR, 0, 0, 0));
		plan_beat(mk_req(ACT_READ, 1, 0, 0));
		plan_beat(mk_req(ACT_READ, 4095, 0, 0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i])
			send_beat(plan[i], 36);

		counted = 0;
		while (counted < INFLUENCE_ITEMS) begin
			if (counted < INFLUENCE_ITEMS / 3)
				cur = PACE_LAZY_SINK;
			else if (counted < 2 * INFLUENCE_ITEMS / 3)
				cur = PACE_LAZY_SOURCE;
			else
				cur = PACE_FULL;
			pace <= cur;
			r = random_req(cur == PACE_FULL && counted < 2 * INFLUENCE_ITEMS / 3 + 20);
			case (cur)
				PACE_LAZY_SINK:   send_beat(r, 36);
				PACE_LAZY_SOURCE: send_beat(r, 70);
				default:          send_beat(r, 0);
			endcase
			if (r.action != ACT_NONE)
				counted++;
		end
		req_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (pending != 0)
			$error("%0d expected beats never arrived", pending);
		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
design/skin4_pkg.sv
design/skin4_table.sv
design/skin4_div.sv
design/skin_influence_top4_accumulator_top.sv
bench/skin4_influence_checker.sv
bench/tb_skin_influence_top4_accumulator_top.sv
